[hw/rtl/kse_pkg.sv]
package kse_pkg;

    localparam int SCAN_W        = 64;
    localparam int KEY_W         = 7;
    localparam int REG_CNT_W     = 4;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 7;
    localparam int BITS_PER_REG  = 8;
    localparam int MAX_REGS      = 8;
    localparam int CHUNK_W       = 3;
    localparam int MAX_RESULTS   = 6;
    localparam int NRES_W        = 3;

    localparam logic [KEY_W-1:0]     MAX_KEY_NUM_RST = 7'd64;
    localparam logic [REG_CNT_W-1:0] REG_COUNT_RST   = 4'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_KEY_NUM  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_COUNT    = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;       // take a new scan
        logic scan_step;  // decode one 8-bit register of the scan
        logic cmp_step;   // move to the next group of eight keys
        logic emit_evt;   // send an event and update the press map
        logic emit_null;  // send the no-change result
    } t_kse_cmd;

    // datapath to controller
    typedef struct packed {
        logic chunk_last; // last group of the walk
        logic chunk_hit;  // a changed key in the current group
        logic diff_none;  // no changed key anywhere in range
        logic evt_last;   // the pending event closes this scan
        logic out_free;   // output register can take a result
    } t_kse_sts;

endpackage

[hw/rtl/kse_dp.sv]
module kse_dp import kse_pkg::*; #(
    parameter int MAX_KEYS      = 64,
    parameter int PRESSED_LIMIT = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [SCAN_W-1:0]     i_scan_bits,
    input  t_kse_cmd              i_cmd,
    output t_kse_sts              o_sts,
    input  logic                  i_evt_stall,
    output logic                  o_evt_valid,
    output logic [KEY_W-1:0]      o_key_number,
    output logic                  o_is_press,
    output logic                  o_event_valid,
    output logic                  o_last_event
);

    localparam int CNT_W  = $clog2(PRESSED_LIMIT + 1);
    localparam int KIDX_W = $clog2(MAX_KEYS);

    logic [KEY_W-1:0]     r_max_key;
    logic [REG_CNT_W-1:0] r_reg_cnt;
    logic [SCAN_W-1:0]    r_scan;
    logic [SCAN_W-1:0]    r_cur;
    logic [CNT_W-1:0]     r_cnt;
    logic [CHUNK_W-1:0]   r_chunk;
    logic [NRES_W-1:0]    r_nres;
    logic [MAX_KEYS-1:0]  r_map;
    logic                 r_out_valid;
    logic [KEY_W-1:0]     r_key_number;
    logic                 r_is_press;
    logic                 r_event_valid;
    logic                 r_last_event;

    logic [REG_CNT_W-1:0]    regs_eff;
    logic                    chunk_on;
    logic [KEY_W-1:0]        top;
    logic [BITS_PER_REG-1:0] scan8;
    logic [BITS_PER_REG-1:0] n_cur8;
    logic [CNT_W-1:0]        n_cnt;
    logic [SCAN_W-1:0]       map_ext;
    logic [SCAN_W-1:0]       top_mask;
    logic [SCAN_W-1:0]       full_diff;
    logic [BITS_PER_REG-1:0] diff8;
    logic [CHUNK_W-1:0]      hit_b;
    logic [CHUNK_W*2-1:0]    k;
    logic [SCAN_W-1:0]       onehot_k;
    logic                    cur_bit;
    logic                    evt_last;
    logic                    out_free;

    assign regs_eff = (r_reg_cnt > REG_CNT_W'(MAX_REGS)) ? REG_CNT_W'(MAX_REGS) : r_reg_cnt;
    assign chunk_on = ({1'b0, r_chunk} < regs_eff);
    assign top      = (r_max_key > KEY_W'(MAX_KEYS)) ? KEY_W'(MAX_KEYS) : r_max_key;
    assign scan8    = r_scan[{r_chunk, 3'b000} +: BITS_PER_REG];

    // first zero bits of this register, up to the rollover limit
    always_comb begin
        n_cur8 = '0;
        n_cnt  = r_cnt;
        for (int b = 0; b < BITS_PER_REG; b++) begin
            if (chunk_on && !scan8[b] && (n_cnt < CNT_W'(PRESSED_LIMIT))) begin
                n_cur8[b] = 1'b1;
                n_cnt     = n_cnt + CNT_W'(1);
            end
        end
    end

    assign map_ext = SCAN_W'(r_map);

    always_comb begin
        for (int j = 0; j < SCAN_W; j++) begin
            top_mask[j] = (KEY_W'(j) < top);
        end
    end

    assign full_diff = (r_cur ^ map_ext) & top_mask;
    assign diff8     = full_diff[{r_chunk, 3'b000} +: BITS_PER_REG];

    // lowest changed key in the group
    always_comb begin
        hit_b = '0;
        for (int b = BITS_PER_REG - 1; b >= 0; b--) begin
            if (diff8[b]) begin
                hit_b = CHUNK_W'(b);
            end
        end
    end

    assign k        = {r_chunk, hit_b};
    assign onehot_k = SCAN_W'(1) << k;
    assign cur_bit  = r_cur[k];
    assign evt_last = ((full_diff & ~onehot_k) == '0) ||
                      (r_nres == NRES_W'(MAX_RESULTS - 1));
    assign out_free = !r_out_valid || !i_evt_stall;

    assign o_sts.chunk_last = (r_chunk == '1);
    assign o_sts.chunk_hit  = |diff8;
    assign o_sts.diff_none  = (full_diff == '0);
    assign o_sts.evt_last   = evt_last;
    assign o_sts.out_free   = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_key   <= MAX_KEY_NUM_RST;
            r_reg_cnt   <= REG_COUNT_RST;
            r_map       <= '0;
            r_cnt       <= '0;
            r_chunk     <= '0;
            r_nres      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MAX_KEY_NUM: r_max_key <= i_cfg_data[KEY_W-1:0];
                    CFG_REG_COUNT:   r_reg_cnt <= i_cfg_data[REG_CNT_W-1:0];
                endcase
            end
            if (i_cmd.load) begin
                r_cnt   <= '0;
                r_chunk <= '0;
                r_nres  <= '0;
            end
            if (i_cmd.scan_step) begin
                r_cnt   <= n_cnt;
                r_chunk <= r_chunk + CHUNK_W'(1);
            end
            if (i_cmd.cmp_step) begin
                r_chunk <= r_chunk + CHUNK_W'(1);
            end
            if (i_cmd.emit_evt) begin
                r_map[k[KIDX_W-1:0]] <= cur_bit;
                r_nres               <= r_nres + NRES_W'(1);
            end
            if (i_cmd.emit_evt || i_cmd.emit_null) begin
                r_out_valid <= 1'b1;
            end else if (!i_evt_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_scan <= i_scan_bits;
            r_cur  <= '0;
        end
        if (i_cmd.scan_step) begin
            r_cur[{r_chunk, 3'b000} +: BITS_PER_REG] <= n_cur8;
        end
        if (i_cmd.emit_evt) begin
            r_key_number  <= {1'b0, k} + KEY_W'(1);
            r_is_press    <= cur_bit;
            r_event_valid <= 1'b1;
            r_last_event  <= evt_last;
        end else if (i_cmd.emit_null) begin
            r_key_number  <= '0;
            r_is_press    <= 1'b0;
            r_event_valid <= 1'b0;
            r_last_event  <= 1'b1;
        end
    end

    assign o_evt_valid   = r_out_valid;
    assign o_key_number  = r_key_number;
    assign o_is_press    = r_is_press;
    assign o_event_valid = r_event_valid;
    assign o_last_event  = r_last_event;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_evt || i_cmd.emit_null) |-> out_free)
        else $error("result loaded over a held result");

    a_nres_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= NRES_W'(MAX_RESULTS))
        else $error("too many events for one scan");

    a_null_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_null |-> (r_nres == '0))
        else $error("no-change result after an event");

    a_null_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_event_valid) |-> r_last_event)
        else $error("no-change result not marked last");

endmodule

[hw/rtl/kse_ctrl.sv]
module kse_ctrl import kse_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_scan_valid,
    output logic     o_scan_stall,
    input  t_kse_sts i_sts,
    output t_kse_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CMP
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_scan_stall = (r_state != ST_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_scan_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.chunk_last) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (i_sts.diff_none) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit_null = 1'b1;
                        n_state         = ST_IDLE;
                    end
                end else if (i_sts.chunk_hit) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit_evt = 1'b1;
                        if (i_sts.evt_last) begin
                            n_state = ST_IDLE;
                        end
                    end
                end else begin
                    o_cmd.cmp_step = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.scan_step, o_cmd.cmp_step,
                  o_cmd.emit_evt, o_cmd.emit_null}))
        else $error("more than one datapath command");

    a_scan_to_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && i_sts.chunk_last) |=> (r_state == ST_CMP))
        else $error("scan decode did not hand over to compare");

endmodule

[hw/rtl/key_scan_event_generator.sv]
// decode: the eight scan registers are decoded one 8-bit register per cycle, then the
//   compare walk visits eight keys per cycle, pausing on a group while it emits events
//   and while the output register is held; one scan in flight at a time: a new scan is
//   taken only after the last result of the previous one is loaded
// reset: synchronous active low; all keys released, max_key_num 64, register_count 8
module key_scan_event_generator import kse_pkg::*; #(
    parameter int MAX_KEYS      = 64,
    parameter int PRESSED_LIMIT = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // scan request channel
    input  logic                  i_scan_valid,
    output logic                  o_scan_stall,
    input  logic [SCAN_W-1:0]     i_scan_bits,
    // event request channel
    output logic                  o_evt_valid,
    input  logic                  i_evt_stall,
    output logic [KEY_W-1:0]      o_key_number,
    output logic                  o_is_press,
    output logic                  o_event_valid,
    output logic                  o_last_event
);

    // command and status between the sequencer and the datapath
    t_kse_cmd cmd;
    t_kse_sts sts;

    // sequencer: idle -> decode the eight scan registers -> walk the key groups,
    // emitting one event per cycle whenever the output register is free
    kse_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_scan_valid (i_scan_valid),
        .o_scan_stall (o_scan_stall),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    // datapath: config registers, scan decode with rollover limit, press map,
    // per-group change search and the output register that decouples the
    // event consumer from the walk
    kse_dp #(
        .MAX_KEYS      (MAX_KEYS),
        .PRESSED_LIMIT (PRESSED_LIMIT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_scan_bits   (i_scan_bits),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_evt_stall   (i_evt_stall),
        .o_evt_valid   (o_evt_valid),
        .o_key_number  (o_key_number),
        .o_is_press    (o_is_press),
        .o_event_valid (o_event_valid),
        .o_last_event  (o_last_event)
    );

endmodule

[sim/testbench.sv]
module testbench;
    import kse_pkg::*;

    localparam int KEYS_TOTAL   = 64;
    localparam int PRESS_LIMIT  = 3;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES  = 300;

    // one event request as it leaves the block
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             press;
        logic             valid;
        logic             last;
    } evt_t;

    typedef enum logic {ROW_SCAN, ROW_CFG} row_kind_t;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    // one line of the directed table
    typedef struct packed {
        row_kind_t         kind;
        logic [SCAN_W-1:0] bits;
        logic [6:0]        limit_val;
        logic [6:0]        regs_val;
        logic              typed;
        evt_t              want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = CFG_MAX_KEY_NUM;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic scan_valid = 1'b0;
    logic [SCAN_W-1:0] scan_bits = '1;
    logic evt_stall = 1'b0;
    logic scan_stall;
    logic evt_valid;
    logic [KEY_W-1:0] key_number;
    logic is_press;
    logic event_valid;
    logic last_event;

    key_scan_event_generator dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_scan_valid  (scan_valid),
        .o_scan_stall  (scan_stall),
        .i_scan_bits   (scan_bits),
        .o_evt_valid   (evt_valid),
        .i_evt_stall   (evt_stall),
        .o_key_number  (key_number),
        .o_is_press    (is_press),
        .o_event_valid (event_valid),
        .o_last_event  (last_event)
    );

    always #10 clk = ~clk;

    // predictor state, mirrors the block after reset
    logic [KEYS_TOTAL-1:0] press_map = '0;
    logic [6:0]            key_limit = 7'd64;
    logic [3:0]            key_regs  = 4'd8;
    evt_t                  derived_events [0:MAX_RESULTS-1];
    evt_t                  awaited_events [$];

    int          err_count  = 0;
    int          burst_left = 0;
    logic [SCAN_W-1:0] last_scan = '1;
    bit          hold_req   = 1'b0;
    int          hold_left  = 0;
    stall_mode_t stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int          rx_cycle   = 0;

    task automatic report_mismatch(input string what, input int got, input int want_v);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want_v, $time);
        err_count++;
    endtask

    // decode the scan into pressed keys, walk the checked range against the map
    function automatic int derive_key_events(input logic [SCAN_W-1:0] scan);
        logic [KEYS_TOTAL-1:0] down;
        int regs, top, cnt, n, b, k;
        down = '0;
        cnt = 0;
        n = 0;
        regs = (key_regs > MAX_REGS) ? MAX_REGS : key_regs;
        top = (key_limit > KEYS_TOTAL) ? KEYS_TOTAL : key_limit;
        // zero bits past the rollover limit are dropped, wherever they sit
        for (b = 0; b < regs * BITS_PER_REG; b++) begin
            if (!scan[b] && cnt < PRESS_LIMIT) begin
                down[b] = 1'b1;
                cnt++;
            end
        end
        // keys not reached once the result budget is spent keep their state
        for (k = 0; k < top && n < MAX_RESULTS; k++) begin
            if (down[k] != press_map[k]) begin
                press_map[k] = down[k];
                derived_events[n] = {7'(k + 1), down[k], 1'b1, 1'b0};
                n++;
            end
        end
        if (n == 0) begin
            derived_events[0] = {7'd0, 1'b0, 1'b0, 1'b1};
            n = 1;
        end else begin
            derived_events[n-1].last = 1'b1;
        end
        return n;
    endfunction

    // sender side: bursts of back-to-back requests with random gaps between them
    task automatic offer_scan(input logic [SCAN_W-1:0] bits);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                scan_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        scan_valid <= 1'b1;
        scan_bits  <= bits;
        @(posedge clk);
        while (scan_stall) @(posedge clk);
    endtask

    task automatic scan_item(input logic [SCAN_W-1:0] bits, input logic typed, input evt_t want);
        int n, j;
        offer_scan(bits);
        n = derive_key_events(bits);
        if (typed) begin
            awaited_events.push_back(want);
        end else begin
            for (j = 0; j < n; j++) awaited_events.push_back(derived_events[j]);
        end
    endtask

    // sender pauses until every event has come back and the block has settled
    task automatic wait_idle();
        scan_valid <= 1'b0;
        while (awaited_events.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [6:0] limit_val, input logic [6:0] regs_val);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_MAX_KEY_NUM;
        cfg_data <= limit_val;
        @(posedge clk);
        key_limit = limit_val;
        cfg_idx  <= CFG_REG_COUNT;
        cfg_data <= regs_val;
        @(posedge clk);
        key_regs = regs_val[3:0];
        cfg_we <= 1'b0;
    endtask

    // mostly a few pressed keys on an idle scan, with repeats and raw noise mixed in
    function automatic logic [SCAN_W-1:0] gen_scan();
        logic [SCAN_W-1:0] s;
        int kind, zeros, span, z;
        kind = $urandom_range(0, 9);
        span = (key_regs == 0 || key_regs > MAX_REGS) ? SCAN_W : key_regs * BITS_PER_REG;
        if (key_limit >= 1 && key_limit < span && $urandom_range(0, 1) == 1)
            span = key_limit;
        if (kind == 0) begin
            s = {$urandom, $urandom};
        end else if (kind == 1) begin
            s = last_scan;
        end else if (kind == 2) begin
            s = '1;
        end else begin
            s = '1;
            zeros = $urandom_range(1, 4);
            for (z = 0; z < zeros; z++) begin
                if ($urandom_range(0, 3) == 0)
                    s[$urandom_range(0, SCAN_W - 1)] = 1'b0;
                else
                    s[$urandom_range(0, span - 1)] = 1'b0;
            end
        end
        last_scan = s;
        return s;
    endfunction

    function automatic stim_row_t scan_row(input logic [SCAN_W-1:0] bits);
        stim_row_t r;
        r = '0;
        r.kind = ROW_SCAN;
        r.bits = bits;
        return r;
    endfunction

    function automatic stim_row_t typed_row(input logic [SCAN_W-1:0] bits, input int key,
                                            input logic press, input logic valid,
                                            input logic last);
        stim_row_t r;
        r = scan_row(bits);
        r.typed = 1'b1;
        r.want = {7'(key), press, valid, last};
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [6:0] limit_val, input logic [6:0] regs_val);
        stim_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.limit_val = limit_val;
        r.regs_val = regs_val;
        return r;
    endfunction

    // receiver side: checks each accepted event request, then picks the next stall
    always @(posedge clk) begin : event_sink
        evt_t want;
        logic stall_next;
        if (rst_n && evt_valid && !evt_stall) begin
            if (awaited_events.size() == 0) begin
                report_mismatch("event request with none pending", key_number, 0);
            end else begin
                want = awaited_events.pop_front();
                if (key_number !== want.key)
                    report_mismatch("key_number", key_number, want.key);
                if (is_press !== want.press)
                    report_mismatch("is_press", is_press, want.press);
                if (event_valid !== want.valid)
                    report_mismatch("event_valid", event_valid, want.valid);
                if (last_event !== want.last)
                    report_mismatch("last_event", last_event, want.last);
            end
        end
        rx_cycle++;
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (mode_left == 0) begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        case (stall_mode)
            STALL_NONE:     stall_next = 1'b0;
            STALL_LIGHT:    stall_next = ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    stall_next = ($urandom_range(0, 3) != 0);
            default:        stall_next = ((rx_cycle % 5) < 2);
        endcase
        // long hold-off so the block backs up and stalls its scan input
        if (hold_left > 0) begin
            stall_next = 1'b1;
            hold_left--;
        end
        evt_stall <= stall_next;
    end

    initial begin
        stim_row_t dir_rows [$];
        stim_row_t row;
        int i, phase, item;
        logic [6:0] limit_val, regs_val;

        // reset map: all released, limit 64, eight registers
        dir_rows.push_back(typed_row('1, 0, 1'b0, 1'b0, 1'b1));
        dir_rows.push_back(typed_row(~64'h1, 1, 1'b1, 1'b1, 1'b1));
        dir_rows.push_back(typed_row('1, 1, 1'b0, 1'b1, 1'b1));
        dir_rows.push_back(typed_row(~(64'h1 << 63), 64, 1'b1, 1'b1, 1'b1));
        // everything low: only the lowest three count
        dir_rows.push_back(scan_row('0));
        dir_rows.push_back(typed_row('0, 0, 1'b0, 1'b0, 1'b1));
        // five keys down, two beyond the rollover limit
        dir_rows.push_back(scan_row(~((64'h1 << 10) | (64'h1 << 20) | (64'h1 << 30) |
                                      (64'h1 << 40) | (64'h1 << 50))));
        // key limit zero checks nothing
        dir_rows.push_back(cfg_row(7'd0, 7'd8));
        dir_rows.push_back(typed_row('0, 0, 1'b0, 1'b0, 1'b1));
        // key limit above the key count acts as 64
        dir_rows.push_back(cfg_row(7'd127, 7'd8));
        dir_rows.push_back(scan_row('0));
        // register count zero: no key pressed
        dir_rows.push_back(cfg_row(7'd64, 7'd0));
        dir_rows.push_back(scan_row('0));
        // one register: bit 8 lies outside the scan
        dir_rows.push_back(cfg_row(7'd64, 7'd1));
        dir_rows.push_back(typed_row(~(64'h1 << 8), 0, 1'b0, 1'b0, 1'b1));
        // register count field above 8, upper data bits set
        dir_rows.push_back(cfg_row(7'd64, 7'h7F));
        dir_rows.push_back(typed_row(~(64'h1 << 63), 64, 1'b1, 1'b1, 1'b1));
        // build up stored presses above a lowered limit, then raise it again
        dir_rows.push_back(cfg_row(7'd60, 7'd8));
        dir_rows.push_back(scan_row(~(64'h7 << 57)));
        dir_rows.push_back(cfg_row(7'd56, 7'd8));
        dir_rows.push_back(scan_row(~(64'h7 << 53)));
        dir_rows.push_back(cfg_row(7'd64, 7'd8));
        // more changes than one scan may report
        dir_rows.push_back(scan_row(~64'h7));
        dir_rows.push_back(scan_row('1));
        dir_rows.push_back(scan_row('1));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < dir_rows.size(); i++) begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG)
                write_config(row.limit_val, row.regs_val);
            else
                scan_item(row.bits, row.typed, row.want);
        end

        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    limit_val = 7'd64;
                    regs_val = 7'd8;
                end
                1: begin
                    limit_val = 7'd1;
                    regs_val = 7'd1;
                end
                3: begin
                    limit_val = 7'($urandom_range(65, 127));
                    regs_val = 7'($urandom_range(9, 127));
                end
                default: begin
                    limit_val = 7'($urandom_range(1, 64));
                    regs_val = 7'($urandom_range(1, 8));
                end
            endcase
            write_config(limit_val, regs_val);
            if (phase == 2) hold_req = 1'b1;
            for (item = 0; item < 20; item++)
                scan_item(gen_scan(), 1'b0, '0);
        end

        wait_idle();
        if (err_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #4000000;
        $display("testbench: errors");
        $finish;
    end

endmodule

[key_scan_event_generator.f]
hw/rtl/kse_pkg.sv
hw/rtl/kse_dp.sv
hw/rtl/kse_ctrl.sv
hw/rtl/key_scan_event_generator.sv
sim/testbench.sv
